// File: rtl/tsm_pkg.sv
// tsm_pkg: shared types and constants for the task scheduler with mailboxes
// no dependencies
package tsm_pkg;

    localparam int TaskSlots = 16;
    localparam int RingDepth = 8;
    localparam int WordBits  = 32;
    localparam int SlotW     = $clog2(TaskSlots);
    localparam int RingW     = $clog2(RingDepth);
    localparam int MsgW      = WordBits + SlotW;
    localparam int StoreD    = TaskSlots * RingDepth;
    localparam int StoreAW   = $clog2(StoreD);

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_START   = 3'd2,
        OP_SEND    = 3'd3,
        OP_RECEIVE = 3'd4,
        OP_SLEEP   = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_RING_FULL  = 3'd2,
        ST_RING_EMPTY = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_NO_TASKS   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        TS_UNUSED   = 2'd0,
        TS_READY    = 2'd1,
        TS_BLOCKED  = 2'd2,
        TS_SLEEPING = 2'd3
    } task_state_t;

endpackage

// File: rtl/tsm_ram.sv
// tsm_ram: generic single-port-write, single-read ram with registered read
// no dependencies
module tsm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/task_scheduler_mailbox.sv
// task_scheduler_mailbox: top level, task table, round-robin scheduler, sequencer
// depends on tsm_pkg and tsm_ram (message store)
// sequence: tick runs a wake sweep through the shared compare unit, then a pick sweep,
// one slot a cycle; receive adds a registered read of the message store before the result
// throughput: one request at a time, not ready until the result has been taken
// reset: all tasks unused, tick count zero, used count one, no running task; message store uncleared
module task_scheduler_mailbox
    import tsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], target_pid[6:3], payload[38:7], wake_at[70:39], zero[71]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], result_pid[6:3], out_payload[38:7], running_pid[42:39],
    // running_valid[43], tick_now[75:44], zero[79:76]
    output logic [79:0] m_tdata
);
    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_WAKE, S_PICK, S_READ, S_OUT
    } state_t;

    state_t state_reg;

    // request hold
    logic [2:0]          op_reg;
    logic [SlotW-1:0]    tgt_reg;
    logic [WordBits-1:0] pay_reg;
    logic [31:0]         wake_reg;

    // task table (per-slot registers, one slot touched a cycle)
    task_state_t         tstat_reg [TaskSlots];
    logic [31:0]         wtime_reg [TaskSlots];
    logic [RingW-1:0]    head_reg  [TaskSlots];
    logic [RingW-1:0]    tail_reg  [TaskSlots];
    logic                full_reg  [TaskSlots];

    logic [31:0]         tick_reg;
    logic [SlotW:0]      used_reg;
    logic [SlotW-1:0]    run_reg;
    logic                present_reg;

    // sweep counters
    logic [SlotW-1:0]    idx_reg;
    logic [SlotW:0]      cnt_reg;

    // result
    logic [2:0]          rstat_reg;
    logic [SlotW-1:0]    rpid_reg;
    logic [WordBits-1:0] rpay_reg;

    // message store
    logic                we;
    logic [StoreAW-1:0]  waddr, raddr;
    logic [MsgW-1:0]     wdata, rdata;

    tsm_ram #(.Width(MsgW), .Depth(StoreD)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {4'd0, tick_reg, present_reg, (present_reg ? run_reg : 4'd0),
                       rpay_reg, rpid_reg, rstat_reg};

    // shared compare unit: signed wake difference of the slot under the sweep
    logic [31:0] wdiff;
    logic        wake_due;
    assign wdiff    = wtime_reg[idx_reg] - tick_reg;
    assign wake_due = (wdiff == 32'd0) || wdiff[31];

    logic [SlotW:0] nslots;
    assign nslots = used_reg - 1'b1;

    // next slot in round-robin order among created slots 1..used-1
    logic [SlotW-1:0] idx_wrap;
    assign idx_wrap = ({1'b0, idx_reg} + 1'b1 >= used_reg) ? SlotW'(1)
                                                           : idx_reg + 1'b1;

    logic send_ok;
    assign send_ok = (tgt_reg != '0) && ({1'b0, tgt_reg} < used_reg) && !full_reg[tgt_reg];

    assign we    = (state_reg == S_EXEC) && (op_reg == OP_SEND) && send_ok;
    assign waddr = {tgt_reg, tail_reg[tgt_reg]};
    assign wdata = {(present_reg ? run_reg : 4'd0), pay_reg};
    assign raddr = {run_reg, head_reg[run_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tick_reg    <= '0;
            used_reg    <= (SlotW+1)'(1);
            run_reg     <= '0;
            present_reg <= 1'b0;
            for (int i = 0; i < TaskSlots; i++)
            begin
                tstat_reg[i] <= TS_UNUSED;
                wtime_reg[i] <= '0;
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                full_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= s_tdata[2:0];
                        tgt_reg   <= s_tdata[6:3];
                        pay_reg   <= s_tdata[38:7];
                        wake_reg  <= s_tdata[70:39];
                        rstat_reg <= ST_OK;
                        rpid_reg  <= '0;
                        rpay_reg  <= '0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    case (op_reg)
                        OP_TICK:
                        begin
                            tick_reg  <= tick_reg + 1'b1;
                            idx_reg   <= SlotW'(1);
                            state_reg <= S_WAKE;
                        end
                        OP_CREATE:
                        begin
                            state_reg <= S_OUT;
                            if (used_reg >= (SlotW+1)'(TaskSlots))
                            begin
                                rstat_reg <= ST_TABLE_FULL;
                            end
                            else
                            begin
                                tstat_reg[used_reg[SlotW-1:0]] <= TS_READY;
                                wtime_reg[used_reg[SlotW-1:0]] <= '0;
                                head_reg[used_reg[SlotW-1:0]]  <= '0;
                                tail_reg[used_reg[SlotW-1:0]]  <= '0;
                                full_reg[used_reg[SlotW-1:0]]  <= 1'b0;
                                rpid_reg <= used_reg[SlotW-1:0];
                                used_reg <= used_reg + 1'b1;
                            end
                        end
                        OP_START:
                        begin
                            state_reg <= S_OUT;
                            if (used_reg < (SlotW+1)'(2))
                            begin
                                rstat_reg <= ST_NO_TASKS;
                            end
                            else
                            begin
                                run_reg     <= SlotW'(1);
                                present_reg <= 1'b1;
                            end
                        end
                        OP_SEND:
                        begin
                            state_reg <= S_OUT;
                            if (tgt_reg == '0 || {1'b0, tgt_reg} >= used_reg)
                            begin
                                rstat_reg <= ST_NOT_FOUND;
                            end
                            else if (full_reg[tgt_reg])
                            begin
                                rstat_reg <= ST_RING_FULL;
                            end
                            else
                            begin
                                tail_reg[tgt_reg] <= tail_reg[tgt_reg] + 1'b1;
                                if (tail_reg[tgt_reg] + 1'b1 == head_reg[tgt_reg])
                                begin
                                    full_reg[tgt_reg] <= 1'b1;
                                end
                                if (tstat_reg[tgt_reg] == TS_BLOCKED)
                                begin
                                    tstat_reg[tgt_reg] <= TS_READY;
                                end
                            end
                        end
                        OP_RECEIVE:
                        begin
                            if (!present_reg)
                            begin
                                rstat_reg <= ST_NO_TASKS;
                                state_reg <= S_OUT;
                            end
                            else if (!full_reg[run_reg] && head_reg[run_reg] == tail_reg[run_reg])
                            begin
                                tstat_reg[run_reg] <= TS_BLOCKED;
                                rstat_reg          <= ST_RING_EMPTY;
                                state_reg          <= S_OUT;
                            end
                            else
                            begin
                                // ram read address is valid now, data next cycle
                                state_reg <= S_READ;
                            end
                        end
                        OP_SLEEP:
                        begin
                            state_reg <= S_OUT;
                            if (!present_reg)
                            begin
                                rstat_reg <= ST_NO_TASKS;
                            end
                            else
                            begin
                                wtime_reg[run_reg] <= wake_reg;
                                tstat_reg[run_reg] <= TS_SLEEPING;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_WAKE:
                begin
                    // one slot a cycle through the shared compare
                    if ({1'b0, idx_reg} < used_reg && tstat_reg[idx_reg] == TS_SLEEPING
                        && wake_due)
                    begin
                        tstat_reg[idx_reg] <= TS_READY;
                    end
                    if ({1'b0, idx_reg} + 1'b1 >= used_reg || idx_reg == SlotW'(TaskSlots-1))
                    begin
                        if (!present_reg || used_reg < (SlotW+1)'(2))
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            idx_reg   <= ({1'b0, run_reg} + 1'b1 >= used_reg) ? SlotW'(1)
                                                                          : run_reg + 1'b1;
                            cnt_reg   <= '0;
                            state_reg <= S_PICK;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_PICK:
                begin
                    if (tstat_reg[idx_reg] == TS_READY)
                    begin
                        run_reg   <= idx_reg;
                        state_reg <= S_OUT;
                    end
                    else if (cnt_reg + 1'b1 >= nslots)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        idx_reg <= idx_wrap;
                    end
                end
                S_READ:
                begin
                    rpay_reg           <= rdata[WordBits-1:0];
                    rpid_reg           <= rdata[MsgW-1:WordBits];
                    head_reg[run_reg]  <= head_reg[run_reg] + 1'b1;
                    full_reg[run_reg]  <= 1'b0;
                    state_reg          <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // the running slot, when one is present, is always a created slot
    assert property (@(posedge clk) disable iff (!rst_n)
        present_reg |-> ({1'b0, run_reg} < used_reg && run_reg != '0))
        else $error("running slot outside created range");

    // a store write only happens for a created target
    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (tgt_reg != '0 && {1'b0, tgt_reg} < used_reg))
        else $error("store write to uncreated slot");

    // the tick count changes only from the execute state, at most once per request
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(tick_reg))
        else $error("tick count moved outside execute");
endmodule

// File: dv/tb.sv
// tb: self-checking testbench for task_scheduler_mailbox, stream requests in and results out
// depends on rtl/tsm_pkg.sv and rtl/task_scheduler_mailbox.sv
`timescale 1ns / 1ps

module tb;
    import tsm_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int RandomReqs = 1900;
    localparam int HoldAt     = 400;   // request count at which the receiver holds off
    localparam int HoldLen    = 500;   // length of that hold in cycles
    localparam int Drain      = 60;    // longer than a tick sweep

    // request word, last field in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [31:0] wake_at;
        logic [31:0] payload;
        logic [3:0]  target_pid;
        logic [2:0]  opcode;
    } sched_req_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] tick_now;
        logic        running_valid;
        logic [3:0]  running_pid;
        logic [31:0] out_payload;
        logic [3:0]  result_pid;
        logic [2:0]  status;
    } sched_res_t;

    // one row of the directed table; typed rows fix status and result_pid by hand
    typedef struct {
        sched_req_t req;
        bit         typed;
        logic [2:0] status;
        logic [3:0] result_pid;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    task_scheduler_mailbox DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // shadow copy of the task table, rings and scheduler
    logic [1:0]  shadow_state [TaskSlots];
    logic [31:0] shadow_wake  [TaskSlots];
    logic [2:0]  ring_rd      [TaskSlots];
    logic [2:0]  ring_wr      [TaskSlots];
    logic        ring_full    [TaskSlots];
    logic [31:0] mail_word    [TaskSlots][RingDepth];
    logic [3:0]  mail_from    [TaskSlots][RingDepth];
    logic [31:0] shadow_tick;
    int          shadow_used;
    int          cur_slot;
    bit          cur_on;

    sched_res_t    expected_results [$];
    directed_row_t directed [$];

    int  n_sent = 0;
    int  n_mismatch = 0;
    int  n_checked = 0;
    int  status_seen [8];
    int  cycles = 0;
    int  src_idle_pct = 0;
    int  dst_idle_pct = 0;
    bit  hold_done = 0;
    bit  typed_pending = 0;
    logic [2:0] typed_status;
    logic [3:0] typed_pid;

    // apply one request to the shadow state and return what the block should answer
    function automatic sched_res_t schedule_step(sched_req_t r);
        sched_res_t res;
        logic [31:0] diff;
        int s, n, t, h;
        res = '0;
        case (r.opcode)
            OP_TICK: begin
                shadow_tick = shadow_tick + 1;
                // wake sweep: signed distance to the wake time at most zero
                for (s = 1; s < shadow_used; s++) begin
                    if (shadow_state[s] == TS_SLEEPING) begin
                        diff = shadow_wake[s] - shadow_tick;
                        if ($signed(diff) <= 0)
                            shadow_state[s] = TS_READY;
                    end
                end
                // pick sweep: next ready slot after the current one, current last
                if (cur_on && shadow_used >= 2) begin
                    n = shadow_used - 1;
                    for (int k = 1; k <= n; k++) begin
                        s = ((cur_slot - 1 + k) % n) + 1;
                        if (shadow_state[s] == TS_READY) begin
                            cur_slot = s;
                            break;
                        end
                    end
                end
            end
            OP_CREATE: begin
                if (shadow_used >= TaskSlots)
                    res.status = ST_TABLE_FULL;
                else begin
                    s = shadow_used;
                    shadow_state[s] = TS_READY;
                    shadow_wake[s] = '0;
                    ring_rd[s] = '0;
                    ring_wr[s] = '0;
                    ring_full[s] = 1'b0;
                    shadow_used++;
                    res.result_pid = s[3:0];
                end
            end
            OP_START: begin
                if (shadow_used < 2)
                    res.status = ST_NO_TASKS;
                else begin
                    cur_slot = 1;
                    cur_on = 1;
                end
            end
            OP_SEND: begin
                s = r.target_pid;
                if (s == 0 || s >= shadow_used)
                    res.status = ST_NOT_FOUND;
                else if (ring_full[s])
                    res.status = ST_RING_FULL;
                else begin
                    t = ring_wr[s];
                    mail_word[s][t] = r.payload;
                    mail_from[s][t] = cur_on ? cur_slot[3:0] : 4'd0;
                    ring_wr[s] = 3'(t + 1);
                    if (ring_wr[s] == ring_rd[s])
                        ring_full[s] = 1'b1;
                    if (shadow_state[s] == TS_BLOCKED)
                        shadow_state[s] = TS_READY;
                end
            end
            OP_RECEIVE: begin
                if (!cur_on)
                    res.status = ST_NO_TASKS;
                else if (!ring_full[cur_slot] && ring_rd[cur_slot] == ring_wr[cur_slot]) begin
                    shadow_state[cur_slot] = TS_BLOCKED;
                    res.status = ST_RING_EMPTY;
                end else begin
                    h = ring_rd[cur_slot];
                    res.out_payload = mail_word[cur_slot][h];
                    res.result_pid = mail_from[cur_slot][h];
                    ring_rd[cur_slot] = 3'(h + 1);
                    ring_full[cur_slot] = 1'b0;
                end
            end
            OP_SLEEP: begin
                if (!cur_on)
                    res.status = ST_NO_TASKS;
                else begin
                    shadow_wake[cur_slot] = r.wake_at;
                    shadow_state[cur_slot] = TS_SLEEPING;
                end
            end
            default: ;  // spare opcodes do nothing
        endcase
        res.running_pid = cur_on ? cur_slot[3:0] : 4'd0;
        res.running_valid = cur_on;
        res.tick_now = shadow_tick;
        return res;
    endfunction

    initial
    begin
        for (int s = 0; s < TaskSlots; s++)
        begin
            shadow_state[s] = TS_UNUSED;
            shadow_wake[s] = '0;
            ring_rd[s] = '0;
            ring_wr[s] = '0;
            ring_full[s] = 1'b0;
        end
        shadow_tick = '0;
        shadow_used = 1;
        cur_slot = 0;
        cur_on = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        sched_res_t exp_r;
        sched_res_t got;
        if (rst_n && s_tvalid && s_tready)
        begin
            exp_r = schedule_step(sched_req_t'(s_tdata));
            // directed rows with hand-typed answers override the prediction
            if (typed_pending)
            begin
                exp_r.status = typed_status;
                exp_r.result_pid = typed_pid;
            end
            expected_results.push_back(exp_r);
            status_seen[exp_r.status]++;
            n_sent++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = sched_res_t'(m_tdata);
            if (expected_results.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %h with nothing outstanding", m_tdata);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                n_checked++;
                if (got.status !== exp_r.status || got.result_pid !== exp_r.result_pid
                    || got.out_payload !== exp_r.out_payload
                    || got.running_pid !== exp_r.running_pid
                    || got.running_valid !== exp_r.running_valid
                    || got.tick_now !== exp_r.tick_now)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"result %0d: exp st=%0d pid=%0d pay=%h run=%0d/%0b ",
                                  "tick=%0d, got st=%0d pid=%0d pay=%h run=%0d/%0b tick=%0d"},
                                 n_checked, exp_r.status, exp_r.result_pid, exp_r.out_payload,
                                 exp_r.running_pid, exp_r.running_valid, exp_r.tick_now,
                                 got.status, got.result_pid, got.out_payload,
                                 got.running_pid, got.running_valid, got.tick_now);
                end
            end
        end
    end

    // receiver: random back-pressure plus one long hold once the queue has built up
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && n_sent >= HoldAt)
            begin
                hold_done = 1;
                hold_left = HoldLen;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // drive one request, called at a falling edge and returning at one
    task automatic offer_request(sched_req_t r);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(3) != 0)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= r;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic sched_req_t req_of(logic [2:0] op, logic [3:0] tgt,
                                          logic [31:0] pay, logic [31:0] wake);
        sched_req_t r;
        r = '0;
        r.opcode = op;
        r.target_pid = tgt;
        r.payload = pay;
        r.wake_at = wake;
        return r;
    endfunction

    task automatic add_row(sched_req_t r, bit typed, logic [2:0] st, logic [3:0] pid);
        directed_row_t d;
        d.req = r;
        d.typed = typed;
        d.status = st;
        d.result_pid = pid;
        directed.push_back(d);
    endtask

    // random request, mostly well-formed traffic to nonzero target pids
    function automatic sched_req_t random_request();
        sched_req_t r;
        int pick;
        r = '0;
        r.payload = $urandom;
        r.target_pid = ($urandom_range(15) == 0) ? 4'($urandom_range(15))
                                                  : 4'($urandom_range(15, 1));
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: r.wake_at = $urandom;
            1: r.wake_at = shadow_tick - $urandom_range(3);
            default: r.wake_at = shadow_tick + $urandom_range(8);
        endcase
        if (pick < 25)       r.opcode = OP_TICK;
        else if (pick < 57)  r.opcode = OP_SEND;
        else if (pick < 82)  r.opcode = OP_RECEIVE;
        else if (pick < 90)  r.opcode = OP_SLEEP;
        else if (pick < 95)  r.opcode = OP_CREATE;
        else if (pick < 98)  r.opcode = OP_START;
        else                 r.opcode = 3'($urandom_range(7, 6));  // spare codes
        return r;
    endfunction

    initial
    begin
        // no task yet: tick counts, receive, sleep, start and send find nothing
        add_row(req_of(OP_TICK, 4'd0, '0, '0), 1, ST_OK, 4'd0);
        add_row(req_of(OP_RECEIVE, 4'd0, '0, '0), 1, ST_NO_TASKS, 4'd0);
        add_row(req_of(OP_SLEEP, 4'd0, '0, '1), 1, ST_NO_TASKS, 4'd0);
        add_row(req_of(OP_START, 4'd0, '0, '0), 1, ST_NO_TASKS, 4'd0);
        add_row(req_of(OP_SEND, 4'd1, '1, '0), 1, ST_NOT_FOUND, 4'd0);
        add_row(req_of(OP_TICK, 4'd0, '0, '0), 0, ST_OK, 4'd0);
        add_row(req_of(OP_CREATE, 4'd0, '0, '0), 1, ST_OK, 4'd1);
        add_row(req_of(OP_CREATE, 4'd15, '1, '1), 1, ST_OK, 4'd2);
        // pid zero is never a task
        add_row(req_of(OP_SEND, 4'd0, 32'h1234_5678, '0), 1, ST_NOT_FOUND, 4'd0);
        // send with no running task records sender zero
        add_row(req_of(OP_SEND, 4'd1, '1, '0), 0, ST_OK, 4'd0);
        add_row(req_of(OP_START, 4'd0, '0, '0), 1, ST_OK, 4'd0);
        add_row(req_of(OP_RECEIVE, 4'd0, '0, '0), 0, ST_OK, 4'd0);
        // empty ring blocks the current task, which stays current
        add_row(req_of(OP_RECEIVE, 4'd0, '0, '0), 1, ST_RING_EMPTY, 4'd0);
        add_row(req_of(OP_TICK, 4'd0, '0, '0), 0, ST_OK, 4'd0);
        add_row(req_of(OP_SEND, 4'd15, '0, '0), 1, ST_NOT_FOUND, 4'd0);
        add_row(req_of(OP_SEND, 4'd1, 32'h0000_0000, '1), 0, ST_OK, 4'd0);
        // sleeping target keeps its mail but stays asleep
        add_row(req_of(OP_SLEEP, 4'd0, '0, 32'd40), 0, ST_OK, 4'd0);
        add_row(req_of(OP_SEND, 4'd2, 32'hA5A5_5A5A, '0), 0, ST_OK, 4'd0);
        add_row(req_of(OP_TICK, 4'd0, '0, '0), 0, ST_OK, 4'd0);
        // wake time far behind in signed terms wakes at once
        add_row(req_of(OP_SLEEP, 4'd0, '0, 32'h8000_0006), 0, ST_OK, 4'd0);
        add_row(req_of(OP_TICK, 4'd0, '0, '0), 0, ST_OK, 4'd0);
        add_row(req_of(3'd6, 4'd7, '1, '1), 1, ST_OK, 4'd0);
        add_row(req_of(3'd7, 4'd8, '0, '0), 1, ST_OK, 4'd0);
        add_row(req_of(OP_START, 4'd0, '0, '0), 1, ST_OK, 4'd0);

        src_idle_pct = 8;
        dst_idle_pct = 68;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            typed_pending = directed[i].typed;
            typed_status = directed[i].status;
            typed_pid = directed[i].result_pid;
            offer_request(directed[i].req);
        end
        typed_pending = 0;

        // three idling phases: sender light/receiver heavy, swapped, then none
        for (int i = 0; i < RandomReqs; i++)
        begin
            if (i == RandomReqs / 3)
            begin
                src_idle_pct = 68;
                dst_idle_pct = 8;
            end
            else if (i == 2 * RandomReqs / 3)
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            offer_request(random_request());
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (Drain) @(posedge clk);

        $display("checked %0d results: %0d ok, %0d unknown pid, %0d ring full, %0d ring empty,",
                 n_checked, status_seen[ST_OK], status_seen[ST_NOT_FOUND],
                 status_seen[ST_RING_FULL], status_seen[ST_RING_EMPTY]);
        $display("%0d table full, %0d no task; %0d mismatches over %0d ticks",
                 status_seen[ST_TABLE_FULL], status_seen[ST_NO_TASKS], n_mismatch, shadow_tick);
        if (n_mismatch == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
